FILE: sv/first_fit_block_allocator_top_defines.svh
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FFBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffba: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffba: next-cycle check failed");

`endif

FILE: sv/ffba_pkg.sv
// Package: constants, codes and types of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HEADER_BYTES = 32'd32;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_END   = 1'b1;

    typedef logic [2:0] t_status;
    localparam t_status STAT_REUSED   = 3'd0;
    localparam t_status STAT_NEW      = 3'd1;
    localparam t_status STAT_ZERO     = 3'd2;
    localparam t_status STAT_NOSPACE  = 3'd3;
    localparam t_status STAT_FREED    = 3'd4;
    localparam t_status STAT_NOTFOUND = 3'd5;

    typedef struct packed {
        logic        used;
        logic [31:0] size;
        logic [31:0] base;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_entry;
    } t_mem_req;

endpackage
`default_nettype wire

FILE: sv/ffba_in_if.sv
// Request channel: allocate or free word.
`default_nettype none
interface ffba_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] elem_bytes;
    logic [15:0] elem_count;
    logic [31:0] free_address;

    modport source (output valid, output action, output elem_bytes, output elem_count,
                    output free_address, input ready);
    modport sink   (input valid, input action, input elem_bytes, input elem_count,
                    input free_address, output ready);
endinterface
`default_nettype wire

FILE: sv/ffba_out_if.sv
// Response channel: data address and status word.
`default_nettype none
interface ffba_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_address;
    logic [2:0]  status;

    modport source (output valid, output data_address, output status, input ready);
    modport sink   (input valid, input data_address, input status, output ready);
endinterface
`default_nettype wire

FILE: sv/ffba_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffba_table (
    input  wire logic                i_clk,
    input  wire ffba_pkg::t_mem_req  i_req,
    output ffba_pkg::t_entry         o_rd_entry
);

    ffba_pkg::t_entry r_mem [ffba_pkg::MAX_BLOCKS];
    ffba_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        r_rd_entry <= r_mem[i_req.rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule
`default_nettype wire

FILE: sv/ffba_ctrl.sv
// Sequencer: setup, table scan, append, response hold and configuration registers.
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"
module ffba_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ffba_in_if.sink                    i_req,
    ffba_out_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [31:0]           i_cfg_data,
    output ffba_pkg::t_mem_req         o_mem,
    input  wire ffba_pkg::t_entry      i_rd_entry
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic                        r_action;
    logic [31:0]                 r_want;
    logic [32:0]                 r_want_hdr;
    logic [31:0]                 r_addr;
    logic [ffba_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [ffba_pkg::CNT_W-1:0]  r_count, n_count;
    logic [31:0]                 r_break, n_break;
    logic [31:0]                 r_heap_start;
    logic [31:0]                 r_heap_end;
    logic [31:0]                 r_res_addr, n_res_addr;
    ffba_pkg::t_status           r_res_stat, n_res_stat;
    logic                        r_out_valid;
    logic [31:0]                 r_out_addr;
    ffba_pkg::t_status           r_out_stat;

    logic [ffba_pkg::CNT_W-1:0]  idx_next;
    logic                        hit;
    logic [33:0]                 new_break;
    logic                        out_load;

    assign idx_next  = ffba_pkg::CNT_W'(r_idx + 1'b1);
    assign hit       = (r_action == ffba_pkg::ACT_ALLOC)
                       ? (!i_rd_entry.used && (i_rd_entry.size >= r_want))
                       : ((i_rd_entry.base + ffba_pkg::HEADER_BYTES) == r_addr);
    assign new_break = {2'b00, r_break} + {1'b0, r_want_hdr};
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.data_address = r_out_addr;
    assign o_rsp.status       = r_out_stat;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_break    = r_break;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        o_mem.rd_addr  = idx_next[ffba_pkg::IDX_W-1:0];
        o_mem.wr_en    = 1'b0;
        o_mem.wr_addr  = r_idx[ffba_pkg::IDX_W-1:0];
        o_mem.wr_entry = i_rd_entry;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_mem.rd_addr = '0;
                n_idx         = '0;
                n_res_addr    = '0;
                if (r_action == ffba_pkg::ACT_ALLOC && r_want == '0) begin
                    n_res_stat = ffba_pkg::STAT_ZERO;
                    n_state    = S_DONE;
                end else if (r_action == ffba_pkg::ACT_FREE && r_addr == '0) begin
                    n_res_stat = ffba_pkg::STAT_NOTFOUND;
                    n_state    = S_DONE;
                end else if (r_count == '0) begin
                    n_res_stat = ffba_pkg::STAT_NOTFOUND;
                    n_state    = (r_action == ffba_pkg::ACT_ALLOC) ? S_APPEND : S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    o_mem.wr_en         = 1'b1;
                    o_mem.wr_entry.used = (r_action == ffba_pkg::ACT_ALLOC);
                    if (r_action == ffba_pkg::ACT_ALLOC) begin
                        n_res_addr = i_rd_entry.base + ffba_pkg::HEADER_BYTES;
                        n_res_stat = ffba_pkg::STAT_REUSED;
                    end else begin
                        n_res_stat = ffba_pkg::STAT_FREED;
                    end
                    n_state = S_DONE;
                end else if (idx_next == r_count) begin
                    n_res_stat = ffba_pkg::STAT_NOTFOUND;
                    n_state    = (r_action == ffba_pkg::ACT_ALLOC) ? S_APPEND : S_DONE;
                end else begin
                    n_idx = idx_next;
                end
            end
            S_APPEND: begin
                o_mem.wr_addr = r_count[ffba_pkg::IDX_W-1:0];
                if (r_count == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)
                        || new_break > {2'b00, r_heap_end}) begin
                    n_res_stat = ffba_pkg::STAT_NOSPACE;
                end else begin
                    o_mem.wr_en          = 1'b1;
                    o_mem.wr_entry.used  = 1'b1;
                    o_mem.wr_entry.size  = r_want;
                    o_mem.wr_entry.base  = r_break;
                    n_count    = ffba_pkg::CNT_W'(r_count + 1'b1);
                    n_break    = new_break[31:0];
                    n_res_addr = r_break + ffba_pkg::HEADER_BYTES;
                    n_res_stat = ffba_pkg::STAT_NEW;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we && i_cfg_idx == ffba_pkg::CFG_HEAP_START && r_count == '0) begin
            n_break = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_break      <= '0;
            r_heap_start <= '0;
            r_heap_end   <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_break <= n_break;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ffba_pkg::CFG_HEAP_START: r_heap_start <= i_cfg_data;
                    ffba_pkg::CFG_HEAP_END:   r_heap_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_want   <= {16'd0, i_req.elem_bytes} * {16'd0, i_req.elem_count};
            r_addr   <= i_req.free_address;
        end
        if (r_state == S_SETUP) begin
            r_want_hdr <= {1'b0, r_want} + {1'b0, ffba_pkg::HEADER_BYTES};
        end
        r_idx      <= n_idx;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
        if (out_load) begin
            r_out_addr <= r_res_addr;
            r_out_stat <= r_res_stat;
        end
    end

    `FFBA_ASSERT_IMPLY(a_wr_state, i_clk, i_rst_n, o_mem.wr_en,
        r_state == S_SCAN || r_state == S_APPEND)
    `FFBA_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1,
        r_count <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
    `FFBA_ASSERT_IMPLY(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, r_idx < r_count)
    `FFBA_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, o_mem.wr_en && r_state == S_APPEND,
        r_count == ffba_pkg::CNT_W'($past(r_count) + 1'b1))
    `FFBA_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, out_load, r_out_valid)

endmodule
`default_nettype wire

FILE: sv/first_fit_block_allocator_top.sv
// Sequence: a taken request goes through setup, then a first-fit scan of the table
// entries (at most 64) until a hit, then an append for an allocate with no hit, and
// then loads the response register; a zero size or a null free skips scan and append.
// One word at a time: the next request is taken in the cycle after the response
// register loads; a held response stalls it.
// Reset (synchronous, active low) empties the table, sets the break and heap start
// to 0 and the heap end to all ones; table contents are not cleared.
`default_nettype none
module first_fit_block_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffba_in_if.sink          i_req,
    ffba_out_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    ffba_pkg::t_mem_req mem_req;
    ffba_pkg::t_entry   rd_entry;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mem      (mem_req),
        .i_rd_entry (rd_entry)
    );

    ffba_table u_table (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

endmodule
`default_nettype wire
